// File: rtl/adc_cfd_word_pair_decoder_unit_defines.svh
// Assertion macros for the ADC/CFD word pair decoder.
// Used by the top level; no other dependencies.
`ifndef ADC_CFD_WORD_PAIR_DECODER_UNIT_DEFINES_SVH
`define ADC_CFD_WORD_PAIR_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACWPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acwpd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ACWPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acwpd next-cycle check failed");

`endif

// File: rtl/acwpd_pkg.sv
// Package for the ADC/CFD word pair decoder: field positions, word types, hit record.
// No dependencies.
`default_nettype none

package acwpd_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned TIME_W     = 28;
    localparam int unsigned TOP_W      = 20;
    localparam int unsigned HIT_TIME_W = TOP_W + TIME_W;
    localparam int unsigned TYPE_LSB   = 62;
    localparam int unsigned ADDR_LSB   = 48;
    localparam int unsigned VALUE_LSB  = 32;
    localparam int unsigned PAIR_BIT   = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Word type codes from the two top bits.
    typedef enum logic [1:0] {
        WT_ZERO  = 2'd0,
        WT_ONE   = 2'd1,
        WT_TOP   = 2'd2,
        WT_EVENT = 2'd3
    } word_type_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     hit_address;
        logic [VALUE_W-1:0]    energy_value;
        logic [VALUE_W-1:0]    cfd_value;
        logic [HIT_TIME_W-1:0] hit_time;
    } hit_t;

    // Decoder state seen by the top level.
    typedef struct packed {
        logic             pending_valid;
        logic [TOP_W-1:0] top_time;
    } core_status_t;

endpackage

`default_nettype wire

// File: rtl/acwpd_word_if.sv
// Valid/ready channel interfaces for raw words and decoded hits.
// Depends on acwpd_pkg.
`default_nettype none

interface acwpd_word_if
    import acwpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] raw_word;
    logic              block_last;

    modport source (output valid, output raw_word, output block_last, input ready);
    modport sink (input valid, input raw_word, input block_last, output ready);
endinterface

interface acwpd_hit_if
    import acwpd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ADDR_W-1:0]     hit_address;
    logic [VALUE_W-1:0]    energy_value;
    logic [VALUE_W-1:0]    cfd_value;
    logic [HIT_TIME_W-1:0] hit_time;

    modport source (output valid, output hit_address, output energy_value,
                    output cfd_value, output hit_time, input ready);
    modport sink (input valid, input hit_address, input energy_value,
                  input cfd_value, input hit_time, output ready);
endinterface

`default_nettype wire

// File: rtl/acwpd_pair_core.sv
// Pair decoder core: top-time and pending-word state, partner match, hit build.
// Depends on acwpd_pkg.
`default_nettype none

module acwpd_pair_core
    import acwpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [WORD_W-1:0] raw_word,
    input  wire logic              block_last,
    output      logic              hit_valid,
    output      hit_t              hit,
    output      core_status_t      status
);

    logic [TOP_W-1:0]   top_time_reg, top_time_next;
    logic               pending_valid_reg, pending_valid_next;
    logic [ADDR_W-1:0]  pending_address_reg, pending_address_next;
    logic [VALUE_W-1:0] pending_value_reg, pending_value_next;
    logic [TIME_W-1:0]  pending_time_reg, pending_time_next;

    word_type_t         w_type;
    logic [ADDR_W-1:0]  w_addr;
    logic [VALUE_W-1:0] w_value;
    logic [TIME_W-1:0]  w_time;
    logic [ADDR_W:0]    pend_plus;
    logic [ADDR_W:0]    addr_plus;
    logic               time_match;
    logic               pend_is_adc;
    logic               word_is_adc;

    // Field extraction.
    assign w_type  = word_type_t'(raw_word[WORD_W-1:TYPE_LSB]);
    assign w_addr  = raw_word[ADDR_LSB +: ADDR_W];
    assign w_value = raw_word[VALUE_LSB +: VALUE_W];
    assign w_time  = raw_word[TIME_W-1:0];

    // Partner test in either order; sums are one bit wider so they never wrap.
    assign pend_plus   = {1'b0, pending_address_reg} + (ADDR_W+1)'(1 << PAIR_BIT);
    assign addr_plus   = {1'b0, w_addr} + (ADDR_W+1)'(1 << PAIR_BIT);
    assign time_match  = pending_valid_reg && (pending_time_reg == w_time);
    assign pend_is_adc = time_match && !pending_address_reg[PAIR_BIT]
                         && ({1'b0, w_addr} == pend_plus);
    assign word_is_adc = time_match && !w_addr[PAIR_BIT]
                         && ({1'b0, pending_address_reg} == addr_plus);

    assign hit_valid = pend_is_adc || word_is_adc;

    // Hit record; the lower address is the energy word.
    always_comb
    begin
        if (pend_is_adc)
        begin
            hit.hit_address  = pending_address_reg;
            hit.energy_value = pending_value_reg;
            hit.cfd_value    = w_value;
        end
        else
        begin
            hit.hit_address  = w_addr;
            hit.energy_value = w_value;
            hit.cfd_value    = pending_value_reg;
        end
        hit.hit_time = {top_time_reg, w_time};
    end

    // State update for one processed word.
    always_comb
    begin
        top_time_next        = top_time_reg;
        pending_valid_next   = pending_valid_reg;
        pending_address_next = pending_address_reg;
        pending_value_next   = pending_value_reg;
        pending_time_next    = pending_time_reg;
        if (step)
        begin
            pending_valid_next = 1'b0;
            if (!hit_valid && !block_last)
            begin
                unique case (w_type)
                    WT_TOP:
                    begin
                        top_time_next = raw_word[VALUE_LSB +: TOP_W];
                    end
                    WT_EVENT:
                    begin
                        pending_valid_next   = 1'b1;
                        pending_address_next = w_addr;
                        pending_value_next   = w_value;
                        pending_time_next    = w_time;
                    end
                    WT_ZERO, WT_ONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_time_reg        <= '0;
            pending_valid_reg   <= 1'b0;
            pending_address_reg <= '0;
            pending_value_reg   <= '0;
            pending_time_reg    <= '0;
        end
        else
        begin
            top_time_reg        <= top_time_next;
            pending_valid_reg   <= pending_valid_next;
            pending_address_reg <= pending_address_next;
            pending_value_reg   <= pending_value_next;
            pending_time_reg    <= pending_time_next;
        end
    end

    assign status.pending_valid = pending_valid_reg;
    assign status.top_time      = top_time_reg;

endmodule

`default_nettype wire

// File: rtl/adc_cfd_word_pair_decoder_unit.sv
// Path: input stage register, combinational decode, then the two-entry hit
// queue, whose head is offered on the hit channel when it holds a hit.
// Throughput: one word per cycle, limited by the single decode stage, unless
// the queue is full and not drained; it lets words flow while a hit waits.
// Reset: rst_n clears top time, pending word, input stage and hit queue.
// ADC/CFD word pair decoder top level; depends on acwpd_pkg, the channel
// interfaces, acwpd_pair_core and the assertion macro header.
`default_nettype none
`include "adc_cfd_word_pair_decoder_unit_defines.svh"

module adc_cfd_word_pair_decoder_unit
    import acwpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    acwpd_word_if.sink    words,
    acwpd_hit_if.source   hits
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic              stage_valid_reg, stage_valid_next;
    logic [WORD_W-1:0] stage_word_reg;
    logic              stage_last_reg;

    logic              in_fire;
    logic              proc_fire;
    logic              out_fire;
    logic              push;
    logic              queue_room;

    logic              core_hit_valid;
    hit_t              core_hit;
    core_status_t      core_status;

    hit_t              q_data_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  q_wr_ptr_reg, q_rd_ptr_reg;
    logic [CNT_W-1:0]  q_count_reg, q_count_next;
    hit_t              q_head;

    // Handshakes.
    assign queue_room  = (q_count_reg != CNT_W'(QUEUE_DEPTH)) || hits.ready;
    assign proc_fire   = stage_valid_reg && queue_room;
    assign words.ready = !stage_valid_reg || proc_fire;
    assign in_fire     = words.valid && words.ready;
    assign out_fire    = hits.valid && hits.ready;
    assign push        = proc_fire && core_hit_valid;

    // Input stage register.
    assign stage_valid_next = in_fire || (stage_valid_reg && !proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_word_reg <= words.raw_word;
            stage_last_reg <= words.block_last;
        end
    end

    // Decode stage.
    acwpd_pair_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (proc_fire),
        .raw_word   (stage_word_reg),
        .block_last (stage_last_reg),
        .hit_valid  (core_hit_valid),
        .hit        (core_hit),
        .status     (core_status)
    );

    // Hit queue, two entries.
    always_comb
    begin
        q_count_next = q_count_reg;
        if (push && !out_fire)
        begin
            q_count_next = q_count_reg + CNT_W'(1);
        end
        else if (!push && out_fire)
        begin
            q_count_next = q_count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg  <= '0;
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (push)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + PTR_W'(1);
            end
            if (out_fire)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[q_wr_ptr_reg] <= core_hit;
        end
    end

    // Output channel.
    assign q_head            = q_data_reg[q_rd_ptr_reg];
    assign hits.valid        = (q_count_reg != '0);
    assign hits.hit_address  = q_head.hit_address;
    assign hits.energy_value = q_head.energy_value;
    assign hits.cfd_value    = q_head.cfd_value;
    assign hits.hit_time     = q_head.hit_time;

    // A hit needs a pending word behind it.
    `ACWPD_ASSERT_IMPL(a_hit_needs_pending, clk, rst_n, core_hit_valid,
                       core_status.pending_valid)
    // The last word of a block always leaves nothing pending.
    `ACWPD_ASSERT_NEXT(a_last_clears_pending, clk, rst_n, proc_fire && stage_last_reg,
                       !core_status.pending_valid)
    // A full queue that is not drained holds the decode stage.
    `ACWPD_ASSERT_IMPL(a_full_queue_stalls, clk, rst_n,
                       (q_count_reg == CNT_W'(QUEUE_DEPTH)) && !hits.ready, !proc_fire)
    // A pushed hit is visible on the output in the next cycle.
    `ACWPD_ASSERT_NEXT(a_push_shows_hit, clk, rst_n, push, hits.valid)

endmodule

`default_nettype wire

// File: tb/sv/adc_cfd_word_pair_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ADC/CFD word pair decoder top level.
// Depends on acwpd_pkg, the word and hit channel interfaces and the RTL.
// A directed table runs first, then random pair streams under random idling.
module adc_cfd_word_pair_decoder_unit_tb;
    import acwpd_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int SEGMENT_ITEMS = 100;
    localparam int MAX_IDLE = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam logic [ADDR_W:0] PAIR_STEP = (ADDR_W+1)'(1 << PAIR_BIT);

    // Which side may idle during a stretch of the run.
    typedef enum logic [1:0] {
        IDLE_BOTH,
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER
    } idle_mode_t;

    // One row of the directed table.
    typedef struct {
        logic [WORD_W-1:0] raw;
        logic              last;
        bit                typed;
        bit                typed_has;
        hit_t              typed_hit;
    } directed_row_t;

    logic clk;
    logic rst_n;

    acwpd_word_if word_ch ();
    acwpd_hit_if  hit_ch ();

    adc_cfd_word_pair_decoder_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .words (word_ch.sink),
        .hits  (hit_ch.source)
    );

    // Decoder state as the testbench tracks it.
    logic [TOP_W-1:0]   top_time_q;
    logic               held_valid;
    logic [ADDR_W-1:0]  held_addr;
    logic [VALUE_W-1:0] held_value;
    logic [TIME_W-1:0]  held_time;

    hit_t          expected_hits[$];
    directed_row_t directed_rows[$];
    idle_mode_t    idle_mode;
    int            mismatch_count;
    int            cycle_count;

    // Clock and cycle limit.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("adc_cfd_word_pair_decoder_unit_tb NOT OK");
            $finish;
        end
    end

    // Build a raw word; fill supplies the unused bits 61:60 and 31:28.
    function automatic logic [WORD_W-1:0] mk_word(word_type_t ty, logic [ADDR_W-1:0] addr,
                                                  logic [VALUE_W-1:0] value,
                                                  logic [TIME_W-1:0] tm, logic [5:0] fill);
        return {ty, fill[5:4], addr, value, fill[3:0], tm};
    endfunction

    // Predict the hit caused by one word and advance the tracked state.
    function automatic bit decode_word(input logic [WORD_W-1:0] raw, input logic last,
                                       output hit_t h);
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  tm;
        bit                 found;

        addr  = raw[ADDR_LSB +: ADDR_W];
        value = raw[VALUE_LSB +: VALUE_W];
        tm    = raw[TIME_W-1:0];
        found = 1'b0;
        h     = '0;

        // A held event word pairs only with the very next word.
        if (held_valid)
        begin
            held_valid = 1'b0;
            if (held_time == tm)
            begin
                if (!held_addr[PAIR_BIT] && {1'b0, addr} == {1'b0, held_addr} + PAIR_STEP)
                begin
                    h.hit_address  = held_addr;
                    h.energy_value = held_value;
                    h.cfd_value    = value;
                    h.hit_time     = {top_time_q, held_time};
                    found = 1'b1;
                end
                else if (!addr[PAIR_BIT] && {1'b0, held_addr} == {1'b0, addr} + PAIR_STEP)
                begin
                    h.hit_address  = addr;
                    h.energy_value = value;
                    h.cfd_value    = held_value;
                    h.hit_time     = {top_time_q, tm};
                    found = 1'b1;
                end
            end
        end

        // A word that did not complete a pair is decoded on its own, except the last one.
        if (!found && !last)
        begin
            case (word_type_t'(raw[TYPE_LSB +: 2]))
                WT_TOP:
                begin
                    top_time_q = raw[VALUE_LSB +: TOP_W];
                end
                WT_EVENT:
                begin
                    held_valid = 1'b1;
                    held_addr  = addr;
                    held_value = value;
                    held_time  = tm;
                end
                default:
                begin
                end
            endcase
        end

        if (last)
            held_valid = 1'b0;
        return found;
    endfunction

    task automatic add_row(input logic [WORD_W-1:0] raw, input logic last, input bit typed,
                           input bit typed_has, input hit_t typed_hit);
        directed_row_t r;

        r.raw       = raw;
        r.last      = last;
        r.typed     = typed;
        r.typed_has = typed_has;
        r.typed_hit = typed_hit;
        directed_rows.push_back(r);
    endtask

    // Offer one word after a random gap; entered and left at a falling edge.
    task automatic send_word(input logic [WORD_W-1:0] raw, input logic last, input bit typed,
                             input bit typed_has, input hit_t typed_hit);
        int   gap;
        bit   has;
        hit_t h;

        gap = (idle_mode == IDLE_BOTH || idle_mode == IDLE_SENDER) ?
              $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.raw_word   <= raw;
        word_ch.block_last <= last;

        do
            @(posedge clk);
        while (!word_ch.ready);

        has = decode_word(raw, last, h);
        if (typed)
        begin
            has = typed_has;
            h   = typed_hit;
        end
        if (has)
            expected_hits.push_back(h);
        @(negedge clk);
    endtask

    // Stop offering words until every predicted hit has been taken.
    task automatic drain_hits();
        word_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_hits.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input hit_t want, input hit_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected addr %h energy %h cfd %h time %h, ",
                      "got addr %h energy %h cfd %h time %h"},
                     $realtime, what, want.hit_address, want.energy_value, want.cfd_value,
                     want.hit_time, got.hit_address, got.energy_value, got.cfd_value,
                     got.hit_time);
    endtask

    // Check every hit transfer against the oldest prediction.
    always @(posedge clk)
    begin : hit_check
        hit_t got;
        hit_t want;

        if (rst_n && hit_ch.valid && hit_ch.ready)
        begin
            got = {hit_ch.hit_address, hit_ch.energy_value, hit_ch.cfd_value, hit_ch.hit_time};
            if (expected_hits.size() == 0)
            begin
                report_mismatch("unexpected hit", '0, got);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (want.hit_address !== got.hit_address ||
                    want.energy_value !== got.energy_value ||
                    want.cfd_value !== got.cfd_value ||
                    want.hit_time !== got.hit_time)
                    report_mismatch("hit field mismatch", want, got);
            end
        end
    end

    // Hit receiver: a random stall before each transfer.
    initial
    begin
        int stall;

        hit_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = (idle_mode == IDLE_BOTH || idle_mode == IDLE_RECEIVER) ?
                    $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0)
            begin
                hit_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            hit_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && hit_ch.valid && hit_ch.ready));
        end
    end

    // Main stimulus.
    initial
    begin
        int                 sent;
        int                 kind;
        int                 next_segment;
        bit                 mid_drain_done;
        logic [ADDR_W-1:0]  a_adc;
        logic [ADDR_W-1:0]  a_cfd;
        logic [TIME_W-1:0]  t;
        logic [TIME_W-1:0]  t2;
        logic [WORD_W-1:0]  w1;
        logic [WORD_W-1:0]  w2;
        bit                 swap;
        logic               first_last;

        rst_n              = 1'b0;
        word_ch.valid      = 1'b0;
        word_ch.raw_word   = '0;
        word_ch.block_last = 1'b0;
        idle_mode          = IDLE_BOTH;
        mismatch_count     = 0;
        cycle_count        = 0;
        top_time_q         = '0;
        held_valid         = 1'b0;
        held_addr          = '0;
        held_value         = '0;
        held_time          = '0;

        // Directed table: typed hits where they follow directly from the word fields.
        // First pair arrives before any top time, ADC word first.
        add_row(mk_word(WT_EVENT, 12'h000, 16'hFFFF, 28'h0, 6'h0), 1'b0, 1, 0, '0);
        add_row(mk_word(WT_ZERO, 12'h010, 16'h0000, 28'h0, 6'h0), 1'b0, 1, 1,
                {12'h000, 16'hFFFF, 16'h0000, 48'h0});
        // All-ones top time, then a CFD-first pair at the top of the address range.
        add_row(64'hBFFF_FFFF_FFFF_FFFF, 1'b0, 1, 0, '0);
        add_row(64'hFFFF_1234_FFFF_FFFF, 1'b0, 1, 0, '0);
        add_row(64'h7FEF_ABCD_FFFF_FFFF, 1'b0, 1, 1,
                {12'hFEF, 16'hABCD, 16'h1234, 48'hFFFF_FFFF_FFFF});
        // Time mismatch drops the held word; a type-2 partner leaves the top time alone.
        add_row(mk_word(WT_EVENT, 12'h020, 16'h0001, 28'h5, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_EVENT, 12'h030, 16'h0002, 28'h6, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_TOP, 12'h020, 16'h0003, 28'h6, 6'h0), 1'b0, 0, 0, '0);
        // Address gap of 32 fails; the last word of a block still completes a pair.
        add_row(mk_word(WT_EVENT, 12'h100, 16'h0004, 28'h7, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_EVENT, 12'h120, 16'h0005, 28'h7, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_ZERO, 12'h130, 16'h0006, 28'h7, 6'h0), 1'b1, 0, 0, '0);
        // A last type-2 word that pairs with nothing loads no top time.
        add_row(mk_word(WT_EVENT, 12'h200, 16'h0007, 28'h9, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_TOP, 12'h500, 16'h0000, 28'h9, 6'h0), 1'b1, 0, 0, '0);
        add_row(mk_word(WT_EVENT, 12'h210, 16'h0008, 28'h9, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_ZERO, 12'h200, 16'h0009, 28'h9, 6'h0), 1'b0, 0, 0, '0);
        // A last event word is never held.
        add_row(mk_word(WT_EVENT, 12'h000, 16'h000A, 28'h0, 6'h0), 1'b1, 0, 0, '0);
        add_row(mk_word(WT_ONE, 12'h010, 16'h000B, 28'h0, 6'h0), 1'b0, 0, 0, '0);
        // Zero top time, then a pair of two event words; the partner is not held.
        add_row(mk_word(WT_TOP, 12'h000, 16'h0000, 28'h0, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_EVENT, 12'h01F, 16'h000C, 28'hABCDEF0, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_EVENT, 12'h00F, 16'h000D, 28'hABCDEF0, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_ZERO, 12'h01F, 16'h000E, 28'hABCDEF0, 6'h0), 1'b0, 0, 0, '0);
        // Lower address with bit 4 set is no ADC word; the failing word is held again.
        add_row(mk_word(WT_EVENT, 12'h010, 16'h000F, 28'h1, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_EVENT, 12'h020, 16'h0010, 28'h1, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_ONE, 12'h030, 16'h0011, 28'h1, 6'h0), 1'b0, 0, 0, '0);
        add_row(mk_word(WT_ZERO, 12'h000, 16'h0000, 28'h0, 6'h0), 1'b1, 0, 0, '0);

        // Reset is held at the start and released at a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].raw, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].typed_has, directed_rows[i].typed_hit);

        // Let every hit out before the random part.
        drain_hits();

        sent           = 0;
        next_segment   = 0;
        mid_drain_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_segment)
            begin
                idle_mode    = idle_mode_t'($urandom_range(0, 3));
                next_segment = next_segment + SEGMENT_ITEMS;
            end
            if (!mid_drain_done && sent >= RANDOM_ITEMS / 2)
            begin
                drain_hits();
                mid_drain_done = 1'b1;
            end

            // ADC address has bit 4 clear, so adding 16 never carries.
            a_adc = 12'($urandom);
            a_adc[PAIR_BIT] = 1'b0;
            a_cfd = a_adc + 12'(PAIR_STEP);
            t     = 28'($urandom);
            t2    = t;
            swap  = $urandom_range(0, 1);
            kind  = $urandom_range(0, 99);

            if (kind < 55)
            begin
                // Well-formed pair in either order with a partner of any type.
                w1 = mk_word(WT_EVENT, swap ? a_cfd : a_adc, 16'($urandom), t, 6'($urandom));
                w2 = mk_word(word_type_t'($urandom_range(0, 3)), swap ? a_adc : a_cfd,
                             16'($urandom), t, 6'($urandom));
                send_word(w1, 1'b0, 0, 0, '0);
                send_word(w2, $urandom_range(0, 9) == 0, 0, 0, '0);
                sent = sent + 2;
            end
            else if (kind < 65)
            begin
                // New top time with random content.
                w1 = {$urandom, $urandom};
                w1[TYPE_LSB +: 2] = WT_TOP;
                send_word(w1, $urandom_range(0, 7) == 0, 0, 0, '0);
                sent = sent + 1;
            end
            else if (kind < 75)
            begin
                // Lone event word.
                w1 = {$urandom, $urandom};
                w1[TYPE_LSB +: 2] = WT_EVENT;
                send_word(w1, $urandom_range(0, 7) == 0, 0, 0, '0);
                sent = sent + 1;
            end
            else if (kind < 85)
            begin
                // Broken pair: one field of the partner relation spoiled.
                case ($urandom_range(0, 2))
                    0: t2 = t ^ (28'd1 << $urandom_range(0, TIME_W - 1));
                    1: a_cfd = a_cfd ^ (12'd1 << $urandom_range(0, ADDR_W - 1));
                    default:
                    begin
                        a_adc[PAIR_BIT] = 1'b1;
                        a_cfd = a_adc + 12'(PAIR_STEP);
                    end
                endcase
                first_last = $urandom_range(0, 15) == 0;
                w1 = mk_word(WT_EVENT, swap ? a_cfd : a_adc, 16'($urandom), t, 6'($urandom));
                w2 = mk_word(word_type_t'($urandom_range(0, 3)), swap ? a_adc : a_cfd,
                             16'($urandom), t2, 6'($urandom));
                send_word(w1, first_last, 0, 0, '0);
                send_word(w2, $urandom_range(0, 7) == 0, 0, 0, '0);
                sent = sent + 2;
            end
            else if (kind < 92)
            begin
                // Fully random word.
                send_word({$urandom, $urandom}, $urandom_range(0, 3) == 0, 0, 0, '0);
                sent = sent + 1;
            end
            else
            begin
                // Type 0 or 1 word; it matters only when a word is held, which it pairs with or drops.
                w1 = {$urandom, $urandom};
                w1[TYPE_LSB +: 2] = word_type_t'($urandom_range(0, 1));
                send_word(w1, $urandom_range(0, 1), 0, 0, '0);
                sent = sent + 1;
            end
        end

        // Wait out the remaining hits, then keep watching for stray hits before the verdict.
        drain_hits();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("adc_cfd_word_pair_decoder_unit_tb OK");
        else
            $display("adc_cfd_word_pair_decoder_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: adc_cfd_word_pair_decoder_unit.f
+incdir+rtl
rtl/acwpd_pkg.sv
rtl/acwpd_word_if.sv
rtl/acwpd_pair_core.sv
rtl/adc_cfd_word_pair_decoder_unit.sv
tb/sv/adc_cfd_word_pair_decoder_unit_tb.sv
